// File: rtl/core/psis_pkg.sv
// Shared types for the parity split insertion sorter.
// Holds the beat payload structs and the cell control struct; no dependencies.
`default_nettype none

package psis_pkg;

  localparam int unsigned DATA_W = 32;

  typedef logic signed [DATA_W-1:0] word_t;

  // Input beat: one list element.
  typedef struct packed {
    word_t value;
    logic  last;
  } item_t;

  // Output beat: one element of the rearranged list.
  typedef struct packed {
    word_t value_res;
    logic  final_res;
    logic  overflow;
  } res_t;

  // Control shared by every cell of a chain.
  typedef struct packed {
    logic insert;  // place the broadcast word into the sorted row
    logic shift;   // move every word one cell toward the head
  } chain_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/psis_cell.sv
// One compare-and-shift cell of a sorted chain.
// Depends on psis_pkg for the word and control types.
`default_nettype none

module psis_cell #(
  parameter bit DESC = 1'b1
) (
  input  wire                 clk,
  input  psis_pkg::chain_ctrl_t ctrl,
  input  wire                 occ,
  input  psis_pkg::word_t     din,
  input  psis_pkg::word_t     prev_val,
  input  wire                 prev_move,
  input  psis_pkg::word_t     next_val,
  output psis_pkg::word_t     val,
  output logic                move
);

  logic cmp;

  // The new word passes this cell when it belongs in front of the held word.
  // An empty cell always yields, so the first empty cell catches the word.
  always_comb begin
    if (DESC) begin
      cmp = (din >= val);
    end else begin
      cmp = (val >= din);
    end
    move = !occ || cmp;
  end

  // On insert a yielding cell takes its left neighbor's word, or the new word
  // if the neighbor stays put. On shift it takes its right neighbor's word.
  always_ff @(posedge clk) begin
    if (ctrl.insert && move) begin
      val <= prev_move ? prev_val : din;
    end else if (ctrl.shift) begin
      val <= next_val;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/psis_chain.sv
// A row of compare-and-shift cells that keeps one parity group sorted.
// Depends on psis_pkg and psis_cell.
`default_nettype none

module psis_chain #(
  parameter int unsigned DEPTH = 8,
  parameter bit          DESC  = 1'b1,
  localparam int unsigned NW   = $clog2(DEPTH + 1)
) (
  input  wire                   clk,
  input  psis_pkg::chain_ctrl_t ctrl,
  input  wire [NW-1:0]          fill,
  input  psis_pkg::word_t       din,
  output psis_pkg::word_t       head
);

  psis_pkg::word_t vals [DEPTH];
  logic [DEPTH-1:0] moves;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [NW-1:0] IDX = NW'(i);
    psis_pkg::word_t prev_val;
    psis_pkg::word_t next_val;
    logic            prev_move;
    logic            occ;

    // Neighbor links; the ends of the row see a neutral neighbor.
    if (i == 0) begin : g_first
      assign prev_val  = din;
      assign prev_move = 1'b0;
    end else begin : g_mid
      assign prev_val  = vals[i-1];
      assign prev_move = moves[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_val = vals[i];
    end else begin : g_inner
      assign next_val = vals[i+1];
    end

    assign occ = (IDX < fill);

    psis_cell #(
      .DESC(DESC)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .occ      (occ),
      .din      (din),
      .prev_val (prev_val),
      .prev_move(prev_move),
      .next_val (next_val),
      .val      (vals[i]),
      .move     (moves[i])
    );
  end

  assign head = vals[0];

endmodule

`default_nettype wire

// File: rtl/core/parity_split_insertion_sort.sv
// Parity split insertion sorter: the load sequencer, the two cell chains and
// the output register. Depends on psis_pkg, psis_chain and psis_cell.
//
// Elements arrive one beat per cycle while no drain runs. Even positions go
// into a descending row of cells, odd positions into an ascending row; each
// row inserts one element per cycle with every cell comparing against the new
// word in parallel. The beat marked last starts the output: the input stalls
// while the two rows take turns shifting toward their heads and one result
// beat per cycle is emitted in position order while the output does not
// stall. Elements beyond CAPACITY are dropped and every result beat of that
// list carries the overflow flag.
`default_nettype none

module parity_split_insertion_sort #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             item_valid,
  output logic            item_stall,
  input  psis_pkg::item_t item,
  output logic            res_valid,
  input  wire             res_stall,
  output psis_pkg::res_t  res
);

  localparam int unsigned EVEN_DEPTH = (CAPACITY + 1) / 2;
  localparam int unsigned ODD_DEPTH  = CAPACITY / 2;
  localparam int unsigned CW         = $clog2(CAPACITY + 1);
  localparam int unsigned EW         = $clog2(EVEN_DEPTH + 1);
  localparam int unsigned OW         = $clog2(ODD_DEPTH + 1);
  localparam logic [CW-1:0] CAP      = CW'(CAPACITY);

  logic [CW-1:0] count;
  logic          dropped;
  logic          draining;
  logic [CW-1:0] remain;
  logic          odd_turn;
  logic          ovf;

  logic          in_acc;
  logic          out_acc;
  logic          has_room;
  logic          load_out;
  logic [CW:0]   count_p1;
  logic [EW-1:0] even_fill;
  logic [OW-1:0] odd_fill;

  psis_pkg::chain_ctrl_t even_ctrl;
  psis_pkg::chain_ctrl_t odd_ctrl;
  psis_pkg::word_t       even_head;
  psis_pkg::word_t       odd_head;

  // Handshake and sequencing conditions.
  assign item_stall = draining;
  assign in_acc     = item_valid && !item_stall;
  assign out_acc    = res_valid && !res_stall;
  assign has_room   = (count < CAP);
  assign load_out   = draining && (!res_valid || !res_stall);

  // Fill levels of the two rows for the element about to be inserted.
  assign count_p1  = {1'b0, count} + 1'b1;
  assign even_fill = EW'(count_p1 >> 1);
  assign odd_fill  = OW'(count >> 1);

  // Insert into the row of the element's parity; shift the row just read.
  always_comb begin
    even_ctrl.insert = in_acc && has_room && !count[0];
    odd_ctrl.insert  = in_acc && has_room && count[0];
    even_ctrl.shift  = load_out && !odd_turn;
    odd_ctrl.shift   = load_out && odd_turn;
  end

  psis_chain #(
    .DEPTH(EVEN_DEPTH),
    .DESC (1'b1)
  ) u_even (
    .clk (clk),
    .ctrl(even_ctrl),
    .fill(even_fill),
    .din (item.value),
    .head(even_head)
  );

  psis_chain #(
    .DEPTH(ODD_DEPTH),
    .DESC (1'b0)
  ) u_odd (
    .clk (clk),
    .ctrl(odd_ctrl),
    .fill(odd_fill),
    .din (item.value),
    .head(odd_head)
  );

  // Load sequencer: counts stored elements and starts the drain on last.
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      dropped  <= 1'b0;
      draining <= 1'b0;
      remain   <= '0;
      odd_turn <= 1'b0;
      ovf      <= 1'b0;
    end else begin
      if (in_acc) begin
        if (item.last) begin
          draining <= 1'b1;
          remain   <= has_room ? CW'(count_p1) : count;
          ovf      <= dropped || !has_room;
          odd_turn <= 1'b0;
          count    <= '0;
          dropped  <= 1'b0;
        end else if (has_room) begin
          count <= CW'(count_p1);
        end else begin
          dropped <= 1'b1;
        end
      end
      if (load_out) begin
        remain   <= remain - 1'b1;
        odd_turn <= !odd_turn;
        if (remain == CW'(1)) begin
          draining <= 1'b0;
        end
      end
    end
  end

  // Output register: takes the next result beat whenever it is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_out) begin
      res_valid <= 1'b1;
    end else if (out_acc) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res.value_res <= odd_turn ? odd_head : even_head;
      res.final_res <= (remain == CW'(1));
      res.overflow  <= ovf;
    end
  end

  // The drain runs exactly while beats remain to be emitted.
  a_drain_count : assert property (@(posedge clk) disable iff (rst)
    draining == (remain != '0))
    else $error("drain flag and remaining count disagree");

  // Accepting a last beat always starts a drain of at least one beat.
  a_last_starts : assert property (@(posedge clk) disable iff (rst)
    (in_acc && item.last) |=> (draining && remain != '0))
    else $error("last beat did not start the output");

  // No element is stored while a drain is running.
  a_idle_count : assert property (@(posedge clk) disable iff (rst)
    draining |-> (count == '0 && !dropped))
    else $error("list state not cleared during drain");

  // The final beat of a list is loaded only as the drain ends.
  a_final_end : assert property (@(posedge clk) disable iff (rst)
    (load_out && remain == CW'(1)) |=> (!draining && res_valid && res.final_res))
    else $error("final beat not marked at end of drain");

endmodule

`default_nettype wire

// File: tb/parity_split_insertion_sort_tb.sv
// Self-checking testbench for parity_split_insertion_sort: drives lists of
// signed words and checks every rearranged result beat against a predictor.
// Depends on psis_pkg and the RTL of the sorter only.
`timescale 1ns / 100ps

module parity_split_insertion_sort_tb;

  localparam int unsigned CAPACITY = 16;
  localparam time HALF_PERIOD = 6ns;
  localparam time RUN_LIMIT = 2ms;

  // Predicts the rearranged list and holds the result beats still to come.
  class sorted_list_predictor;
    psis_pkg::word_t desc_row[$];   // even positions, largest first
    psis_pkg::word_t asc_row[$];    // odd positions, smallest first
    int unsigned stored;
    bit lost;
    psis_pkg::res_t expected_beats[$];
    int unsigned errors;

    function new();
      stored = 0;
      lost = 1'b0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return expected_beats.size();
    endfunction

    // Files an accepted input beat and queues the list output on its last beat.
    function void note_item(psis_pkg::item_t it);
      int unsigned pos;
      int unsigned k;
      psis_pkg::res_t beat;
      if (stored < CAPACITY) begin
        pos = 0;
        if (stored % 2 == 0) begin
          while (pos < desc_row.size() && $signed(desc_row[pos]) > $signed(it.value))
            pos++;
          desc_row.insert(pos, it.value);
        end else begin
          while (pos < asc_row.size() && $signed(asc_row[pos]) < $signed(it.value))
            pos++;
          asc_row.insert(pos, it.value);
        end
        stored++;
      end else begin
        lost = 1'b1;
      end
      if (!it.last) return;
      // Interleave both rows back into position order.
      for (k = 0; k < stored; k++) begin
        beat.value_res = (k % 2 == 0) ? desc_row[k / 2] : asc_row[k / 2];
        beat.final_res = (k + 1 == stored);
        beat.overflow = lost;
        expected_beats.push_back(beat);
      end
      desc_row.delete();
      asc_row.delete();
      stored = 0;
      lost = 1'b0;
    endfunction

    // Compares an accepted result beat with the oldest expected one.
    function void check_result(psis_pkg::res_t got);
      psis_pkg::res_t want;
      if (expected_beats.size() == 0) begin
        $error("unexpected result beat: value_res %0d", $signed(got.value_res));
        errors++;
        return;
      end
      want = expected_beats.pop_front();
      if (got.value_res !== want.value_res) begin
        $error("value_res mismatch: expected %0d, actual %0d",
               $signed(want.value_res), $signed(got.value_res));
        errors++;
      end
      if (got.final_res !== want.final_res) begin
        $error("final_res mismatch: expected %0b, actual %0b", want.final_res, got.final_res);
        errors++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow mismatch: expected %0b, actual %0b", want.overflow, got.overflow);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  psis_pkg::item_t item = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  psis_pkg::res_t res;

  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  sorted_list_predictor sb = new();

  parity_split_insertion_sort #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Result side: check every accepted beat and stall at random.
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) sb.check_result(res);
    res_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Offers one beat after random idle cycles and returns at the edge it is taken.
  task automatic send_item(input psis_pkg::word_t value, input logic last);
    psis_pkg::item_t it;
    it.value = value;
    it.last = last;
    while ($urandom_range(99) < send_gap_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_item(it);
  endtask

  // Holds the input idle until every queued result beat has arrived.
  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Mostly plain random words, with extremes and a narrow band for ties.
  function automatic psis_pkg::word_t pick_word();
    case ($urandom_range(9))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2, 3: return psis_pkg::word_t'($signed($urandom_range(6)) - 3);
      default: return psis_pkg::word_t'($urandom);
    endcase
  endfunction

  // Random lists until about the given number of elements has been stored.
  task automatic send_random_lists(input int unsigned target);
    int unsigned stored_total;
    int unsigned len;
    int unsigned i;
    stored_total = 0;
    while (stored_total < target) begin
      if ($urandom_range(7) == 0) len = $urandom_range(CAPACITY + 4, CAPACITY + 1);
      else if ($urandom_range(5) == 0) len = CAPACITY;
      else len = $urandom_range(CAPACITY, 1);
      for (i = 0; i < len; i++) send_item(pick_word(), i == len - 1);
      stored_total += (len > CAPACITY) ? CAPACITY : len;
    end
  endtask

  // Stimulus: directed lists, then three random phases with different idling.
  initial begin
    int unsigned i;
    int unsigned phase;
    send_gap_pct = 6;
    recv_stall_pct = 61;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Single-element list holding the largest value.
    send_item(32'sh7fff_ffff, 1'b1);
    // Extremes and ties on both parities.
    send_item(32'sh8000_0000, 1'b0);
    send_item(32'sh7fff_ffff, 1'b0);
    send_item(32'sh8000_0000, 1'b0);
    send_item(32'sh7fff_ffff, 1'b0);
    send_item(32'sh0000_0000, 1'b0);
    send_item(32'shffff_ffff, 1'b1);
    // One element past capacity, the dropped one being the last beat.
    for (i = 0; i <= CAPACITY; i++) send_item(pick_word(), i == CAPACITY);
    wait_drained();

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_gap_pct = 6;
          recv_stall_pct = 61;
        end
        1: begin
          send_gap_pct = 61;
          recv_stall_pct = 6;
        end
        default: begin
          send_gap_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      send_random_lists(92);
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #(RUN_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: parity_split_insertion_sort.f
rtl/core/psis_pkg.sv
rtl/core/psis_cell.sv
rtl/core/psis_chain.sv
rtl/core/parity_split_insertion_sort.sv
tb/parity_split_insertion_sort_tb.sv
